// ===== src/planar_masked_text_blitter_macros.svh =====
// Assertion helpers for the text blitter. Both sample on i_clk and are
// switched off while i_rst_n is low.
`ifndef PLANAR_MASKED_TEXT_BLITTER_MACROS_SVH
`define PLANAR_MASKED_TEXT_BLITTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PMTB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PMTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pmtb_pkg.sv =====
`timescale 1ns / 1ps
package pmtb_pkg;

    // Default screen size in text cells.
    localparam int TEXT_COLUMNS_DEF = 40;
    localparam int TEXT_ROWS_DEF    = 25;

    // Frame: four planes, stored side by side in one word per byte address.
    localparam int PLANES      = 4;
    localparam int PLANE_BYTES = 8192;
    localparam int FRAME_AW    = $clog2(PLANE_BYTES);
    localparam int FRAME_DW    = PLANES * 8;

    // Glyph store.
    localparam int GLYPH_DEPTH = 4096;
    localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
    localparam int GLYPH_BYTES = 4000;
    localparam int CELL_BYTES  = 40;
    localparam int GLYPH_ROWS  = 8;

    // Glyph offsets and code mapping.
    localparam int OFS_ARROW  = 'h0050;
    localparam int OFS_LOWER  = 'h0ac8;
    localparam int OFS_GRAY   = 'h0f28;
    localparam int ARROW_CODE = 'h18;
    localparam int CODE_A     = 'h61;
    localparam int CODE_Z     = 'h7a;
    // Range of non-lowercase codes whose cell lies wholly inside the store.
    localparam int ARROW_FIRST = ARROW_CODE - OFS_ARROW / CELL_BYTES;
    localparam int ARROW_LAST  = ARROW_CODE + (GLYPH_BYTES - CELL_BYTES - OFS_ARROW) / CELL_BYTES;

    // Screen geometry inside a plane.
    localparam int ROW_STRIDE = 320;
    localparam int SCAN_BYTES = 40;

    // Exact division by five for indexes below 4096: (i * 3277) >> 14.
    localparam int DIV5_MUL   = 3277;
    localparam int DIV5_SHIFT = 14;

    // Request kinds.
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_DRAW = 2'd1;
    localparam logic [1:0] KIND_FILL = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [1:0] STATUS_NO_GLYPH  = 2'd2;
    localparam logic [1:0] STATUS_OFFSCREEN = 2'd3;

    typedef struct packed {
        logic                re;
        logic                we;
        logic [GLYPH_AW-1:0] addr;
        logic [7:0]          wdata;
    } t_glyph_req;

    typedef struct packed {
        logic                re;
        logic                we;
        logic [FRAME_AW-1:0] addr;
        logic [FRAME_DW-1:0] wdata;
    } t_frame_req;

endpackage

// ===== src/pmtb_channels.sv =====
`timescale 1ns / 1ps
// Request channel into the blitter.
interface pmtb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [10:0] cell_x;
    logic signed [10:0] cell_y;
    logic [7:0]         char_code;
    logic [5:0]         fill_width;
    logic [4:0]         fill_height;
    logic [11:0]        glyph_index;
    logic [7:0]         glyph_byte;
    logic [1:0]         read_plane;
    logic [12:0]        read_address;

    modport source (
        output valid, kind, cell_x, cell_y, char_code, fill_width, fill_height,
               glyph_index, glyph_byte, read_plane, read_address,
        input  ready
    );
    modport sink (
        input  valid, kind, cell_x, cell_y, char_code, fill_width, fill_height,
               glyph_index, glyph_byte, read_plane, read_address,
        output ready
    );
endinterface

// Result channel out of the blitter.
interface pmtb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] status;

    modport source (output valid, read_data, status, input ready);
    modport sink (input valid, read_data, status, output ready);
endinterface

// ===== src/planar_masked_text_blitter.sv =====
// Planar masked text blitter.
// Requests arrive on i_in (valid/ready); every request gives exactly one
// result on o_out (valid/ready), in request order. A load writes one glyph
// byte, a draw blits one character cell, a fill paints the gray tile over a
// rectangle of cells, and a read returns one frame byte.
// The block works on one request at a time. A load passes S_IDLE and
// S_FINISH, a read S_IDLE, S_READ and S_FINISH. A draw or a fill visits
// each cell in S_CELL, and a cell that lies on screen then steps through
// S_ROW for each glyph row. The pace is set by the single glyph port: each
// of the 8 glyph rows takes 5 glyph reads and one read-modify-write of all
// four planes. After reset the frame store is cleared one word (all four
// planes) per cycle, with i_in.ready low. The glyph store is not cleared.
// A finished result sits in an output register; the next request is taken
// while it waits, and only that request's result stalls until o_out drains.
`timescale 1ns / 1ps
`include "planar_masked_text_blitter_macros.svh"
module planar_masked_text_blitter #(
    parameter int TEXT_COLUMNS = pmtb_pkg::TEXT_COLUMNS_DEF,
    parameter int TEXT_ROWS    = pmtb_pkg::TEXT_ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmtb_in_if.sink   i_in,
    pmtb_out_if.source o_out
);
    import pmtb_pkg::*;

    // Widths of an on-screen column and row number.
    localparam int XW = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
    localparam int YW = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
    localparam logic signed [11:0] COL_LIMIT = 12'(TEXT_COLUMNS);
    localparam logic signed [11:0] ROW_LIMIT = 12'(TEXT_ROWS);

    // Row sequence: steps 0..4 read the mask and four plane bytes, step 5
    // writes the merged word back.
    localparam logic [2:0] STEP_WRITE = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CELL,
        S_ROW,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic [FRAME_AW-1:0] r_clr_addr, n_clr_addr;
    logic r_glyphs_ready, n_glyphs_ready;
    logic r_out_valid, n_out_valid;

    logic [7:0] r_out_data, n_out_data;
    logic [1:0] r_out_status, n_out_status;
    logic [7:0] r_res_data, n_res_data;
    logic [1:0] r_res_status, n_res_status;
    logic [1:0] r_rd_plane, n_rd_plane;
    logic r_is_fill, n_is_fill;
    logic signed [11:0] r_org_x, n_org_x;
    logic signed [11:0] r_org_y, n_org_y;
    logic [5:0] r_fw, n_fw;
    logic [4:0] r_fh, n_fh;
    logic [5:0] r_col, n_col;
    logic [4:0] r_row, n_row;
    logic [GLYPH_AW-1:0] r_glyph_off, n_glyph_off;
    logic [GLYPH_AW-1:0] r_gaddr, n_gaddr;
    logic [FRAME_AW-1:0] r_row_addr, n_row_addr;
    logic [2:0] r_grow, n_grow;
    logic [2:0] r_step, n_step;
    logic [7:0] r_mask, n_mask;
    logic [2:0][7:0] r_pcol, n_pcol;

    t_glyph_req glyph_req;
    t_frame_req frame_req;
    logic [7:0] glyph_rdata;
    logic [FRAME_DW-1:0] frame_rdata;

    pmtb_glyph_ram u_glyph_ram (
        .i_clk   (i_clk),
        .i_req   (glyph_req),
        .o_rdata (glyph_rdata)
    );

    pmtb_frame_ram u_frame_ram (
        .i_clk   (i_clk),
        .i_req   (frame_req),
        .o_rdata (frame_rdata)
    );

    logic in_accept;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_accept = i_in.valid && i_in.ready;

    // Load: bytes whose index is a multiple of five hold inverted data.
    logic [2*GLYPH_AW-1:0] div5_prod;
    logic [GLYPH_AW-1:0] div5_q, div5_q5;
    logic load_in_range, load_invert;
    logic [7:0] load_byte;

    always_comb begin
        div5_prod = (2*GLYPH_AW)'(i_in.glyph_index) * (2*GLYPH_AW)'(DIV5_MUL);
        div5_q = GLYPH_AW'(div5_prod >> DIV5_SHIFT);
        div5_q5 = (div5_q << 2) + div5_q;
        load_invert = (div5_q5 == i_in.glyph_index);
        load_in_range = (i_in.glyph_index < GLYPH_AW'(GLYPH_BYTES));
        load_byte = load_invert ? ~i_in.glyph_byte : i_in.glyph_byte;
    end

    // Draw: map the character code to its glyph cell. Lowercase cells all
    // end inside the store; other codes are valid only in a window whose
    // offset is neither negative nor past the end.
    logic [7:0] d_lower, d_arrow;
    logic code_lower, code_arrow, code_ok;
    logic [GLYPH_AW-1:0] draw_off;

    always_comb begin
        d_lower = i_in.char_code - 8'(CODE_A);
        d_arrow = i_in.char_code - 8'(ARROW_FIRST);
        code_lower = (i_in.char_code >= 8'(CODE_A)) && (i_in.char_code <= 8'(CODE_Z));
        code_arrow = (i_in.char_code >= 8'(ARROW_FIRST)) &&
                     (i_in.char_code <= 8'(ARROW_LAST));
        code_ok = code_lower || code_arrow;
        if (code_lower) begin
            draw_off = GLYPH_AW'(OFS_LOWER) + GLYPH_AW'(d_lower) * GLYPH_AW'(CELL_BYTES);
        end else begin
            draw_off = GLYPH_AW'(OFS_ARROW - (ARROW_CODE - ARROW_FIRST) * CELL_BYTES) +
                       GLYPH_AW'(d_arrow) * GLYPH_AW'(CELL_BYTES);
        end
    end

    // Current cell position, its visibility and its frame base address.
    logic signed [11:0] cell_x, cell_y;
    logic cell_on;
    logic [FRAME_AW-1:0] cell_base;

    always_comb begin
        cell_x = r_org_x + signed'({6'b0, r_col});
        cell_y = r_org_y + signed'({7'b0, r_row});
        cell_on = !cell_x[11] && (cell_x < COL_LIMIT) &&
                  !cell_y[11] && (cell_y < ROW_LIMIT);
        cell_base = FRAME_AW'(cell_x[XW-1:0]) +
                    FRAME_AW'(cell_y[YW-1:0]) * FRAME_AW'(ROW_STRIDE);
    end

    // Walk to the next cell of a fill, row by row; a draw has only one.
    logic adv_done;
    assign adv_done = !r_is_fill ||
                      ((r_col == r_fw - 6'd1) && (r_row == r_fh - 5'd1));

    always_comb begin
        n_state = r_state;
        n_clr_addr = r_clr_addr;
        n_glyphs_ready = r_glyphs_ready;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_data = r_out_data;
        n_out_status = r_out_status;
        n_res_data = r_res_data;
        n_res_status = r_res_status;
        n_rd_plane = r_rd_plane;
        n_is_fill = r_is_fill;
        n_org_x = r_org_x;
        n_org_y = r_org_y;
        n_fw = r_fw;
        n_fh = r_fh;
        n_col = r_col;
        n_row = r_row;
        n_glyph_off = r_glyph_off;
        n_gaddr = r_gaddr;
        n_row_addr = r_row_addr;
        n_grow = r_grow;
        n_step = r_step;
        n_mask = r_mask;
        n_pcol = r_pcol;
        glyph_req = '0;
        frame_req = '0;

        unique case (r_state)
            S_CLEAR: begin
                frame_req.we = 1'b1;
                frame_req.addr = r_clr_addr;
                n_clr_addr = r_clr_addr + FRAME_AW'(1);
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_res_data = '0;
                    n_res_status = STATUS_DONE;
                    n_state = S_FINISH;
                    n_col = '0;
                    n_row = '0;
                    n_org_x = 12'(i_in.cell_x);
                    n_org_y = 12'(i_in.cell_y);
                    n_fw = i_in.fill_width;
                    n_fh = i_in.fill_height;
                    n_rd_plane = i_in.read_plane;
                    unique case (i_in.kind)
                        KIND_LOAD: begin
                            if (load_in_range) begin
                                glyph_req.we = 1'b1;
                                glyph_req.addr = i_in.glyph_index;
                                glyph_req.wdata = load_byte;
                                if (i_in.glyph_index == GLYPH_AW'(GLYPH_BYTES - 1)) begin
                                    n_glyphs_ready = 1'b1;
                                end
                            end
                        end
                        KIND_DRAW: begin
                            if (!r_glyphs_ready) begin
                                n_res_status = STATUS_NOT_READY;
                            end else if (!code_ok) begin
                                n_res_status = STATUS_NO_GLYPH;
                            end else begin
                                n_is_fill = 1'b0;
                                n_glyph_off = draw_off;
                                n_state = S_CELL;
                            end
                        end
                        KIND_FILL: begin
                            if (!r_glyphs_ready) begin
                                n_res_status = STATUS_NOT_READY;
                            end else if ((i_in.fill_width != '0) &&
                                         (i_in.fill_height != '0)) begin
                                n_is_fill = 1'b1;
                                n_glyph_off = GLYPH_AW'(OFS_GRAY);
                                n_state = S_CELL;
                            end
                        end
                        KIND_READ: begin
                            frame_req.re = 1'b1;
                            frame_req.addr = i_in.read_address;
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_data = frame_rdata[{r_rd_plane, 3'b000} +: 8];
                n_state = S_FINISH;
            end
            S_CELL: begin
                if (cell_on) begin
                    n_row_addr = cell_base;
                    n_gaddr = r_glyph_off;
                    n_grow = '0;
                    n_step = '0;
                    n_state = S_ROW;
                end else if (!r_is_fill) begin
                    n_res_status = STATUS_OFFSCREEN;
                    n_state = S_FINISH;
                end else if (adv_done) begin
                    n_state = S_FINISH;
                end else if (r_col == r_fw - 6'd1) begin
                    n_col = '0;
                    n_row = r_row + 5'd1;
                end else begin
                    n_col = r_col + 6'd1;
                end
            end
            S_ROW: begin
                // Glyph bytes of a row are consecutive: mask, then planes 0..3.
                if (r_step != STEP_WRITE) begin
                    glyph_req.re = 1'b1;
                    glyph_req.addr = r_gaddr;
                    n_gaddr = r_gaddr + GLYPH_AW'(1);
                    n_step = r_step + 3'd1;
                end
                if (r_step == 3'd0) begin
                    frame_req.re = 1'b1;
                    frame_req.addr = r_row_addr;
                end
                if (r_step == 3'd1) begin
                    n_mask = glyph_rdata;
                end
                if ((r_step >= 3'd2) && (r_step <= 3'd4)) begin
                    n_pcol[2'(r_step - 3'd2)] = glyph_rdata;
                end
                if (r_step == STEP_WRITE) begin
                    // The frame word read at step 0 is still on the read port.
                    frame_req.we = 1'b1;
                    frame_req.addr = r_row_addr;
                    frame_req.wdata = (frame_rdata & {PLANES{r_mask}}) |
                                      {glyph_rdata, r_pcol[2], r_pcol[1], r_pcol[0]};
                    n_row_addr = r_row_addr + FRAME_AW'(SCAN_BYTES);
                    n_step = '0;
                    n_grow = r_grow + 3'd1;
                    if (r_grow == 3'(GLYPH_ROWS - 1)) begin
                        if (adv_done) begin
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_CELL;
                            if (r_col == r_fw - 6'd1) begin
                                n_col = '0;
                                n_row = r_row + 5'd1;
                            end else begin
                                n_col = r_col + 6'd1;
                            end
                        end
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data = r_res_data;
                    n_out_status = r_res_status;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr_addr <= '0;
            r_glyphs_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr_addr <= n_clr_addr;
            r_glyphs_ready <= n_glyphs_ready;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_status <= n_out_status;
        r_res_data <= n_res_data;
        r_res_status <= n_res_status;
        r_rd_plane <= n_rd_plane;
        r_is_fill <= n_is_fill;
        r_org_x <= n_org_x;
        r_org_y <= n_org_y;
        r_fw <= n_fw;
        r_fh <= n_fh;
        r_col <= n_col;
        r_row <= n_row;
        r_glyph_off <= n_glyph_off;
        r_gaddr <= n_gaddr;
        r_row_addr <= n_row_addr;
        r_grow <= n_grow;
        r_step <= n_step;
        r_mask <= n_mask;
        r_pcol <= n_pcol;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.status = r_out_status;

    `PMTB_ASSERT_NOW(a_glyph_port_single, glyph_req.we, !glyph_req.re, "glyph store read and written in one cycle")
    `PMTB_ASSERT_NOW(a_frame_port_single, frame_req.we, !frame_req.re, "frame store read and written in one cycle")
    `PMTB_ASSERT_NOW(a_frame_write_slot, frame_req.we, (r_state == S_CLEAR) || ((r_state == S_ROW) && (r_step == STEP_WRITE)), "frame store written outside clear or row write-back")
    `PMTB_ASSERT_NEXT(a_ready_sticky, r_glyphs_ready, r_glyphs_ready, "glyph ready flag dropped")
    `PMTB_ASSERT_NEXT(a_cell_end, (r_state == S_ROW) && (r_step == STEP_WRITE) && (&r_grow), (r_state == S_CELL) || (r_state == S_FINISH), "cell did not end after its last row")

endmodule

// ===== src/pmtb_glyph_ram.sv =====
`timescale 1ns / 1ps
module pmtb_glyph_ram (
    input  logic                 i_clk,
    input  pmtb_pkg::t_glyph_req i_req,
    output logic [7:0]           o_rdata
);
    import pmtb_pkg::*;

    logic [7:0] r_mem [GLYPH_DEPTH];
    logic [7:0] r_rdata;

    // Read data holds between reads; the sequencer relies on that.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pmtb_frame_ram.sv =====
`timescale 1ns / 1ps
module pmtb_frame_ram (
    input  logic                          i_clk,
    input  pmtb_pkg::t_frame_req          i_req,
    output logic [pmtb_pkg::FRAME_DW-1:0] o_rdata
);
    import pmtb_pkg::*;

    // One word per byte address; plane p sits in byte lane p.
    logic [FRAME_DW-1:0] r_mem [PLANE_BYTES];
    logic [FRAME_DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
